/* src/three_circle_trilateration_unit_macros.svh */
// assertion macros used by the checker in trl_checker.sv
`ifndef THREE_CIRCLE_TRILATERATION_UNIT_MACROS_SVH
`define THREE_CIRCLE_TRILATERATION_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define TRL_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define TRL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* src/trl_pkg.sv */
// ----------------------------------------------------------------------------
// trl_pkg
// Shared widths, status codes, result type and the square root step.
// ----------------------------------------------------------------------------
package trl_pkg;

  localparam int COORD_W     = 24;
  localparam int RAD_W       = 23;
  localparam int OUT_W       = 26;
  localparam int TOL_W       = 16;
  localparam int IN_TDATA_W  = 216;
  localparam int OUT_TDATA_W = 160;
  localparam int STATUS_W    = 2;

  localparam int SQ_W      = 50;
  localparam int SQ_STEPS  = 25;
  localparam int DIV_W     = 52;
  localparam int DA_STEPS  = 25;
  localparam int DP_STEPS  = 24;

  localparam logic [TOL_W-1:0] TOL_RESET = 16'd1;

  localparam logic [STATUS_W-1:0] ST_NONE    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ONE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TWO     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOMATCH = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0]    status;
    logic signed [OUT_W-1:0] c1x;
    logic signed [OUT_W-1:0] c1y;
    logic signed [OUT_W-1:0] c2x;
    logic signed [OUT_W-1:0] c2y;
    logic signed [OUT_W-1:0] fx;
    logic signed [OUT_W-1:0] fy;
  } trl_out_t;

  typedef struct packed {
    logic [SQ_W-1:0] rem;
    logic [SQ_W-1:0] root;
  } sqrt_t;

  // one digit of the restoring square root
  function automatic sqrt_t sqrt_step(input logic [SQ_W-1:0] rem,
                                      input logic [SQ_W-1:0] root,
                                      input logic [SQ_W-1:0] bitv);
    logic [SQ_W:0] t;
    sqrt_t res;
    t = {1'b0, root} + {1'b0, bitv};
    if ({1'b0, rem} >= t) begin
      res.rem  = rem - t[SQ_W-1:0];
      res.root = (root >> 1) + bitv;
    end else begin
      res.rem  = rem;
      res.root = root >> 1;
    end
    return res;
  endfunction

endpackage

/* src/trl_out_skid.sv */
// ----------------------------------------------------------------------------
// trl_out_skid
// Output register with one skid entry; ready toward the pipeline is registered.
// ----------------------------------------------------------------------------
module trl_out_skid (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  trl_pkg::trl_out_t in_data,
  output logic              in_ready,
  output logic              out_valid,
  output trl_pkg::trl_out_t out_data,
  input  logic              out_ready
);

  logic              skid_valid;
  trl_pkg::trl_out_t skid_data;

  assign in_ready = ~skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_valid && !out_ready) begin
      if (in_valid && !skid_valid) begin
        skid_valid <= 1'b1;
      end
    end else if (skid_valid) begin
      out_valid  <= 1'b1;
      skid_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && !out_ready) begin
      if (in_valid && !skid_valid) begin
        skid_data <= in_data;
      end
    end else if (skid_valid) begin
      out_data <= skid_data;
    end else begin
      out_data <= in_data;
    end
  end

endmodule

/* src/three_circle_trilateration_unit.sv */
// ----------------------------------------------------------------------------
// three_circle_trilateration_unit
// Intersects circles A and B and picks the crossing point that lies on C.
// ----------------------------------------------------------------------------
// Usage
//   s_axis carries one item of three circles (centers and radii, Q16.8);
//   m_axis returns one result item per input item, in order: tuser holds
//   the fix status, tdata the two crossing points and the chosen fix.
//   cfg_wr_en / cfg_wr_data load match_tolerance; write it while idle.
// Throughput and depth
//   one item per cycle while m_axis does not stall. The pipeline depth comes
//   from two 25-step square roots and two long divisions (25 and 24
//   quotient bits), one digit per stage.
// Reset
//   rst clears all valid bits and the skid entry; match_tolerance goes to 1.
// Stall
//   the pipeline advances as one; when m_axis stalls, one more result goes
//   into a skid entry and s_axis_tready then drops until it drains.
// ----------------------------------------------------------------------------
module three_circle_trilateration_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_wr_en,
  input  logic [trl_pkg::TOL_W-1:0]          cfg_wr_data,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // center_a_x, center_a_y, radius_a, center_b_x, center_b_y, radius_b,
  // center_c_x, center_c_y, radius_c, zero pad
  input  logic [trl_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // cross_one_x, cross_one_y, cross_two_x, cross_two_y, fix_x, fix_y, zero pad
  output logic [trl_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // fix_status
  output logic [trl_pkg::STATUS_W-1:0]       m_axis_tuser
);

  localparam int SQ_W     = trl_pkg::SQ_W;
  localparam int SQ_STEPS = trl_pkg::SQ_STEPS;
  localparam int DIV_W    = trl_pkg::DIV_W;
  localparam int DA_STEPS = trl_pkg::DA_STEPS;
  localparam int DP_STEPS = trl_pkg::DP_STEPS;

  typedef struct packed {
    logic               meet;
    logic signed [51:0] k;
    logic [22:0]        ra;
    logic [45:0]        ra2;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        rc;
  } side1_t;

  typedef struct packed {
    logic               meet;
    logic               ksign;
    logic               ovf;
    logic [25:0]        den;
    logic [22:0]        ra;
    logic [45:0]        ra2;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        rc;
  } side2_t;

  typedef struct packed {
    logic               meet;
    logic [24:0]        d;
    logic signed [24:0] dx;
    logic signed [24:0] dy;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        rc;
    logic signed [48:0] pxn;
    logic signed [48:0] pyn;
  } side3_t;

  typedef struct packed {
    logic               meet;
    logic [24:0]        d;
    logic signed [23:0] ax;
    logic signed [23:0] ay;
    logic signed [23:0] cx;
    logic signed [23:0] cy;
    logic [22:0]        rc;
  } side4_t;

  function automatic logic signed [25:0] sat26(input logic signed [26:0] v);
    if (v[26] != v[25]) begin
      return v[26] ? {1'b1, 25'd0} : {1'b0, {25{1'b1}}};
    end
    return v[25:0];
  endfunction

  logic adv;
  logic [trl_pkg::TOL_W-1:0] tol;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= trl_pkg::TOL_RESET;
    end else if (cfg_wr_en) begin
      tol <= cfg_wr_data;
    end
  end

  assign s_axis_tready = adv;

  // input fields
  logic signed [23:0] in_ax, in_ay, in_bx, in_by, in_cx, in_cy;
  logic [22:0]        in_ra, in_rb, in_rc;
  assign in_ax = s_axis_tdata[23:0];
  assign in_ay = s_axis_tdata[47:24];
  assign in_ra = s_axis_tdata[70:48];
  assign in_bx = s_axis_tdata[94:71];
  assign in_by = s_axis_tdata[118:95];
  assign in_rb = s_axis_tdata[141:119];
  assign in_cx = s_axis_tdata[165:142];
  assign in_cy = s_axis_tdata[189:166];
  assign in_rc = s_axis_tdata[212:190];

  // stage a: differences
  logic               sa_vld;
  logic signed [23:0] sa_ax, sa_ay, sa_cx, sa_cy;
  logic [22:0]        sa_ra, sa_rb, sa_rc, sa_rdif;
  logic signed [24:0] sa_dx, sa_dy;
  logic [23:0]        sa_rsum;

  always_ff @(posedge clk) begin
    if (rst) begin
      sa_vld <= 1'b0;
    end else if (adv) begin
      sa_vld <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa_ax   <= in_ax;
      sa_ay   <= in_ay;
      sa_cx   <= in_cx;
      sa_cy   <= in_cy;
      sa_ra   <= in_ra;
      sa_rb   <= in_rb;
      sa_rc   <= in_rc;
      sa_dx   <= 25'(in_bx) - 25'(in_ax);
      sa_dy   <= 25'(in_by) - 25'(in_ay);
      sa_rsum <= {1'b0, in_ra} + {1'b0, in_rb};
      sa_rdif <= (in_ra >= in_rb) ? (in_ra - in_rb) : (in_rb - in_ra);
    end
  end

  // stage b: squares
  logic               sb_vld;
  logic signed [49:0] sb_dx2, sb_dy2;
  logic [45:0]        sb_ra2, sb_rb2, sb_rdif2;
  logic [47:0]        sb_rsum2;
  logic signed [24:0] sb_dx, sb_dy;
  logic signed [23:0] sb_ax, sb_ay, sb_cx, sb_cy;
  logic [22:0]        sb_ra, sb_rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sb_vld <= 1'b0;
    end else if (adv) begin
      sb_vld <= sa_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_dx2   <= sa_dx * sa_dx;
      sb_dy2   <= sa_dy * sa_dy;
      sb_ra2   <= sa_ra * sa_ra;
      sb_rb2   <= sa_rb * sa_rb;
      sb_rsum2 <= sa_rsum * sa_rsum;
      sb_rdif2 <= sa_rdif * sa_rdif;
      sb_dx    <= sa_dx;
      sb_dy    <= sa_dy;
      sb_ax    <= sa_ax;
      sb_ay    <= sa_ay;
      sb_cx    <= sa_cx;
      sb_cy    <= sa_cy;
      sb_ra    <= sa_ra;
      sb_rc    <= sa_rc;
    end
  end

  // stage c: distance squared, K, meet test; feeds the first square root
  logic [49:0]        d2_next;
  logic signed [51:0] k_next;
  logic               meet_next;

  always_comb begin
    d2_next   = $unsigned(sb_dx2) + $unsigned(sb_dy2);
    k_next    = $signed({6'd0, sb_ra2}) - $signed({6'd0, sb_rb2}) + $signed({2'd0, d2_next});
    meet_next = (d2_next != '0) && (d2_next <= {2'd0, sb_rsum2}) &&
                (d2_next >= {4'd0, sb_rdif2});
  end

  logic [SQ_W-1:0] sq1_rem  [0:SQ_STEPS];
  logic [SQ_W-1:0] sq1_root [0:SQ_STEPS];
  side1_t          sq1_sd   [0:SQ_STEPS];
  logic            sq1_vld  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq1_vld[0] <= 1'b0;
    end else if (adv) begin
      sq1_vld[0] <= sb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq1_rem[0]     <= d2_next;
      sq1_root[0]    <= '0;
      sq1_sd[0].meet <= meet_next;
      sq1_sd[0].k    <= k_next;
      sq1_sd[0].ra   <= sb_ra;
      sq1_sd[0].ra2  <= sb_ra2;
      sq1_sd[0].dx   <= sb_dx;
      sq1_sd[0].dy   <= sb_dy;
      sq1_sd[0].ax   <= sb_ax;
      sq1_sd[0].ay   <= sb_ay;
      sq1_sd[0].cx   <= sb_cx;
      sq1_sd[0].cy   <= sb_cy;
      sq1_sd[0].rc   <= sb_rc;
    end
  end

  for (genvar g = 1; g <= SQ_STEPS; g++) begin : g_sq1
    localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - g));
    trl_pkg::sqrt_t st;
    always_comb st = trl_pkg::sqrt_step(sq1_rem[g-1], sq1_root[g-1], BITV);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq1_vld[g] <= 1'b0;
      end else if (adv) begin
        sq1_vld[g] <= sq1_vld[g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq1_rem[g]  <= st.rem;
        sq1_root[g] <= st.root;
        sq1_sd[g]   <= sq1_sd[g-1];
      end
    end
  end

  // stage d: set up K / (2d), rounded half away from zero
  side1_t      s1_last;
  logic [24:0] d_val;
  logic [51:0] kmag;
  logic [51:0] na_next;
  logic [25:0] den_next;

  always_comb begin
    s1_last  = sq1_sd[SQ_STEPS];
    d_val    = sq1_root[SQ_STEPS][24:0];
    kmag     = s1_last.k[51] ? $unsigned(-s1_last.k) : $unsigned(s1_last.k);
    na_next  = kmag + {27'd0, d_val};
    den_next = {d_val, 1'b0};
  end

  logic [DIV_W-1:0]    da_rem [0:DA_STEPS];
  logic [DA_STEPS-1:0] da_q   [0:DA_STEPS];
  side2_t              da_sd  [0:DA_STEPS];
  logic                da_vld [0:DA_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      da_vld[0] <= 1'b0;
    end else if (adv) begin
      da_vld[0] <= sq1_vld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      da_rem[0]       <= na_next;
      da_q[0]         <= '0;
      da_sd[0].meet   <= s1_last.meet;
      da_sd[0].ksign  <= s1_last.k[51];
      // quotient of 2^25 or more is past any radius
      da_sd[0].ovf    <= na_next >= ({26'd0, den_next} << DA_STEPS);
      da_sd[0].den    <= den_next;
      da_sd[0].ra     <= s1_last.ra;
      da_sd[0].ra2    <= s1_last.ra2;
      da_sd[0].dx     <= s1_last.dx;
      da_sd[0].dy     <= s1_last.dy;
      da_sd[0].ax     <= s1_last.ax;
      da_sd[0].ay     <= s1_last.ay;
      da_sd[0].cx     <= s1_last.cx;
      da_sd[0].cy     <= s1_last.cy;
      da_sd[0].rc     <= s1_last.rc;
    end
  end

  for (genvar g = 1; g <= DA_STEPS; g++) begin : g_da
    localparam int SH = DA_STEPS - g;
    logic [DIV_W-1:0] ds;
    assign ds = {26'd0, da_sd[g-1].den} << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        da_vld[g] <= 1'b0;
      end else if (adv) begin
        da_vld[g] <= da_vld[g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        da_sd[g] <= da_sd[g-1];
        if (da_rem[g-1] >= ds) begin
          da_rem[g] <= da_rem[g-1] - ds;
          da_q[g]   <= {da_q[g-1][DA_STEPS-2:0], 1'b1};
        end else begin
          da_rem[g] <= da_rem[g-1];
          da_q[g]   <= {da_q[g-1][DA_STEPS-2:0], 1'b0};
        end
      end
    end
  end

  // stage e: clamp a to [-ra, ra]
  side2_t             s2_last;
  logic [22:0]        qa_next;
  logic signed [23:0] a_next;

  always_comb begin
    s2_last = da_sd[DA_STEPS];
    if (s2_last.ovf || (da_q[DA_STEPS] > {2'd0, s2_last.ra})) begin
      qa_next = s2_last.ra;
    end else begin
      qa_next = da_q[DA_STEPS][22:0];
    end
    a_next = s2_last.ksign ? -$signed({1'b0, qa_next}) : $signed({1'b0, qa_next});
  end

  logic               se_vld;
  logic [22:0]        se_qa;
  logic signed [23:0] se_a;
  side2_t             se_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      se_vld <= 1'b0;
    end else if (adv) begin
      se_vld <= da_vld[DA_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      se_qa <= qa_next;
      se_a  <= a_next;
      se_sd <= s2_last;
    end
  end

  // stage f: a^2 and the center offset products
  logic               sf_vld;
  logic [45:0]        sf_a2;
  logic signed [48:0] sf_pxn, sf_pyn;
  side2_t             sf_sd;

  always_ff @(posedge clk) begin
    if (rst) begin
      sf_vld <= 1'b0;
    end else if (adv) begin
      sf_vld <= se_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sf_a2  <= se_qa * se_qa;
      sf_pxn <= se_sd.dx * se_a;
      sf_pyn <= se_sd.dy * se_a;
      sf_sd  <= se_sd;
    end
  end

  // stage g: ra^2 - a^2 into the second square root
  logic [SQ_W-1:0] sq2_rem  [0:SQ_STEPS];
  logic [SQ_W-1:0] sq2_root [0:SQ_STEPS];
  side3_t          sq2_sd   [0:SQ_STEPS];
  logic            sq2_vld  [0:SQ_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sq2_vld[0] <= 1'b0;
    end else if (adv) begin
      sq2_vld[0] <= sf_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2_rem[0]     <= {4'd0, sf_sd.ra2 - sf_a2};
      sq2_root[0]    <= '0;
      sq2_sd[0].meet <= sf_sd.meet;
      sq2_sd[0].d    <= sf_sd.den[25:1];
      sq2_sd[0].dx   <= sf_sd.dx;
      sq2_sd[0].dy   <= sf_sd.dy;
      sq2_sd[0].ax   <= sf_sd.ax;
      sq2_sd[0].ay   <= sf_sd.ay;
      sq2_sd[0].cx   <= sf_sd.cx;
      sq2_sd[0].cy   <= sf_sd.cy;
      sq2_sd[0].rc   <= sf_sd.rc;
      sq2_sd[0].pxn  <= sf_pxn;
      sq2_sd[0].pyn  <= sf_pyn;
    end
  end

  for (genvar g = 1; g <= SQ_STEPS; g++) begin : g_sq2
    localparam logic [SQ_W-1:0] BITV = {{(SQ_W-1){1'b0}}, 1'b1} << (2 * (SQ_STEPS - g));
    trl_pkg::sqrt_t st;
    always_comb st = trl_pkg::sqrt_step(sq2_rem[g-1], sq2_root[g-1], BITV);
    always_ff @(posedge clk) begin
      if (rst) begin
        sq2_vld[g] <= 1'b0;
      end else if (adv) begin
        sq2_vld[g] <= sq2_vld[g-1];
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        sq2_rem[g]  <= st.rem;
        sq2_root[g] <= st.root;
        sq2_sd[g]   <= sq2_sd[g-1];
      end
    end
  end

  // stage i: perpendicular offset products
  logic               si_vld;
  logic signed [48:0] si_txn, si_tyn;
  side3_t             si_sd;
  logic [22:0]        h_val;

  assign h_val = sq2_root[SQ_STEPS][22:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      si_vld <= 1'b0;
    end else if (adv) begin
      si_vld <= sq2_vld[SQ_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      si_txn <= sq2_sd[SQ_STEPS].dy * $signed({1'b0, h_val});
      si_tyn <= sq2_sd[SQ_STEPS].dx * $signed({1'b0, h_val});
      si_sd  <= sq2_sd[SQ_STEPS];
    end
  end

  // stage j: four divides by d, lanes px, py, tx, ty
  logic signed [48:0] lane_n [0:3];
  logic [48:0]        lane_mag [0:3];

  always_comb begin
    lane_n[0] = si_sd.pxn;
    lane_n[1] = si_sd.pyn;
    lane_n[2] = si_txn;
    lane_n[3] = si_tyn;
    for (int l = 0; l < 4; l++) begin
      lane_mag[l] = lane_n[l][48] ? $unsigned(-lane_n[l]) : $unsigned(lane_n[l]);
    end
  end

  logic [DIV_W-1:0]    dp_rem [0:DP_STEPS][0:3];
  logic [DP_STEPS-1:0] dp_q   [0:DP_STEPS][0:3];
  logic [3:0]          dp_neg [0:DP_STEPS];
  side4_t              dp_sd  [0:DP_STEPS];
  logic                dp_vld [0:DP_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      dp_vld[0] <= 1'b0;
    end else if (adv) begin
      dp_vld[0] <= si_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 4; l++) begin
        dp_rem[0][l] <= {3'd0, lane_mag[l]} + {28'd0, si_sd.d[24:1]};
        dp_q[0][l]   <= '0;
        dp_neg[0][l] <= lane_n[l][48];
      end
      dp_sd[0].meet <= si_sd.meet;
      dp_sd[0].d    <= si_sd.d;
      dp_sd[0].ax   <= si_sd.ax;
      dp_sd[0].ay   <= si_sd.ay;
      dp_sd[0].cx   <= si_sd.cx;
      dp_sd[0].cy   <= si_sd.cy;
      dp_sd[0].rc   <= si_sd.rc;
    end
  end

  for (genvar g = 1; g <= DP_STEPS; g++) begin : g_dp
    localparam int SH = DP_STEPS - g;
    logic [DIV_W-1:0] ds;
    assign ds = {27'd0, dp_sd[g-1].d} << SH;
    always_ff @(posedge clk) begin
      if (rst) begin
        dp_vld[g] <= 1'b0;
      end else if (adv) begin
        dp_vld[g] <= dp_vld[g-1];
      end
    end
    for (genvar l = 0; l < 4; l++) begin : g_lane
      always_ff @(posedge clk) begin
        if (adv) begin
          if (dp_rem[g-1][l] >= ds) begin
            dp_rem[g][l] <= dp_rem[g-1][l] - ds;
            dp_q[g][l]   <= {dp_q[g-1][l][DP_STEPS-2:0], 1'b1};
          end else begin
            dp_rem[g][l] <= dp_rem[g-1][l];
            dp_q[g][l]   <= {dp_q[g-1][l][DP_STEPS-2:0], 1'b0};
          end
        end
      end
    end
    always_ff @(posedge clk) begin
      if (adv) begin
        dp_neg[g] <= dp_neg[g-1];
        dp_sd[g]  <= dp_sd[g-1];
      end
    end
  end

  // stage k: crossing points, saturated
  logic signed [24:0] qs [0:3];
  side4_t             s4_last;

  always_comb begin
    s4_last = dp_sd[DP_STEPS];
    for (int l = 0; l < 4; l++) begin
      qs[l] = dp_neg[DP_STEPS][l] ? -$signed({1'b0, dp_q[DP_STEPS][l]})
                                  : $signed({1'b0, dp_q[DP_STEPS][l]});
    end
  end

  logic               sk_vld, sk_meet;
  logic signed [25:0] sk_p1x, sk_p1y, sk_p2x, sk_p2y;
  logic signed [23:0] sk_cx, sk_cy;
  logic [22:0]        sk_rc;

  always_ff @(posedge clk) begin
    if (rst) begin
      sk_vld <= 1'b0;
    end else if (adv) begin
      sk_vld <= dp_vld[DP_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sk_p1x  <= sat26(27'(s4_last.ax) + 27'(qs[0]) - 27'(qs[2]));
      sk_p1y  <= sat26(27'(s4_last.ay) + 27'(qs[1]) + 27'(qs[3]));
      sk_p2x  <= sat26(27'(s4_last.ax) + 27'(qs[0]) + 27'(qs[2]));
      sk_p2y  <= sat26(27'(s4_last.ay) + 27'(qs[1]) - 27'(qs[3]));
      sk_meet <= s4_last.meet;
      sk_cx   <= s4_last.cx;
      sk_cy   <= s4_last.cy;
      sk_rc   <= s4_last.rc;
    end
  end

  // stage l: offsets to circle c and the tolerance band
  logic signed [26:0] ex1s, ey1s, ex2s, ey2s;

  always_comb begin
    ex1s = 27'(sk_p1x) - 27'(sk_cx);
    ey1s = 27'(sk_p1y) - 27'(sk_cy);
    ex2s = 27'(sk_p2x) - 27'(sk_cx);
    ey2s = 27'(sk_p2y) - 27'(sk_cy);
  end

  logic               sl_vld, sl_meet;
  logic [26:0]        sl_ex1, sl_ey1, sl_ex2, sl_ey2;
  logic [22:0]        sl_lo;
  logic [23:0]        sl_hi;
  logic signed [25:0] sl_p1x, sl_p1y, sl_p2x, sl_p2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sl_vld <= 1'b0;
    end else if (adv) begin
      sl_vld <= sk_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sl_ex1  <= ex1s[26] ? $unsigned(-ex1s) : $unsigned(ex1s);
      sl_ey1  <= ey1s[26] ? $unsigned(-ey1s) : $unsigned(ey1s);
      sl_ex2  <= ex2s[26] ? $unsigned(-ex2s) : $unsigned(ex2s);
      sl_ey2  <= ey2s[26] ? $unsigned(-ey2s) : $unsigned(ey2s);
      sl_lo   <= (sk_rc > {7'd0, tol}) ? (sk_rc - {7'd0, tol}) : '0;
      sl_hi   <= {1'b0, sk_rc} + {8'd0, tol};
      sl_meet <= sk_meet;
      sl_p1x  <= sk_p1x;
      sl_p1y  <= sk_p1y;
      sl_p2x  <= sk_p2x;
      sl_p2y  <= sk_p2y;
    end
  end

  // stage m: squares for the on-circle test
  logic               sm_vld, sm_meet;
  logic [53:0]        sm_ex1, sm_ey1, sm_ex2, sm_ey2;
  logic [45:0]        sm_lo2;
  logic [47:0]        sm_hi2;
  logic signed [25:0] sm_p1x, sm_p1y, sm_p2x, sm_p2y;

  always_ff @(posedge clk) begin
    if (rst) begin
      sm_vld <= 1'b0;
    end else if (adv) begin
      sm_vld <= sl_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sm_ex1  <= sl_ex1 * sl_ex1;
      sm_ey1  <= sl_ey1 * sl_ey1;
      sm_ex2  <= sl_ex2 * sl_ex2;
      sm_ey2  <= sl_ey2 * sl_ey2;
      sm_lo2  <= sl_lo * sl_lo;
      sm_hi2  <= sl_hi * sl_hi;
      sm_meet <= sl_meet;
      sm_p1x  <= sl_p1x;
      sm_p1y  <= sl_p1y;
      sm_p2x  <= sl_p2x;
      sm_p2y  <= sl_p2y;
    end
  end

  // final compare and result selection, registered in the output stage
  logic [54:0]       e1, e2;
  logic              on1, on2;
  trl_pkg::trl_out_t res;

  always_comb begin
    e1  = {1'b0, sm_ex1} + {1'b0, sm_ey1};
    e2  = {1'b0, sm_ex2} + {1'b0, sm_ey2};
    on1 = ({9'd0, sm_lo2} <= e1) && (e1 <= {7'd0, sm_hi2});
    on2 = ({9'd0, sm_lo2} <= e2) && (e2 <= {7'd0, sm_hi2});
    res = '0;
    if (sm_meet) begin
      res.c1x = sm_p1x;
      res.c1y = sm_p1y;
      res.c2x = sm_p2x;
      res.c2y = sm_p2y;
      if (on1) begin
        res.status = trl_pkg::ST_ONE;
        res.fx     = sm_p1x;
        res.fy     = sm_p1y;
      end else if (on2) begin
        res.status = trl_pkg::ST_TWO;
        res.fx     = sm_p2x;
        res.fy     = sm_p2y;
      end else begin
        res.status = trl_pkg::ST_NOMATCH;
      end
    end else begin
      res.status = trl_pkg::ST_NONE;
    end
  end

  trl_pkg::trl_out_t out_data;

  trl_out_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sm_vld),
    .in_data   (res),
    .in_ready  (adv),
    .out_valid (m_axis_tvalid),
    .out_data  (out_data),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = {4'd0, out_data.fy, out_data.fx, out_data.c2y, out_data.c2x,
                         out_data.c1y, out_data.c1x};
  assign m_axis_tuser = out_data.status;

endmodule

/* src/trl_checker.sv */
// ----------------------------------------------------------------------------
// trl_checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "three_circle_trilateration_unit_macros.svh"

module trl_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [trl_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic [trl_pkg::STATUS_W-1:0]    m_axis_tuser
);

  // stalled item must hold
  `TRL_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

  // no intersection means every coordinate is zero
  `TRL_ASSERT_NOW(a_none_zero, m_axis_tvalid && (m_axis_tuser == trl_pkg::ST_NONE), m_axis_tdata == '0, "no-intersection result not zero")

  // no third match means the fix is zero
  `TRL_ASSERT_NOW(a_nomatch_zero, m_axis_tvalid && (m_axis_tuser == trl_pkg::ST_NOMATCH), m_axis_tdata[155:104] == '0, "fix not zero without match")

  // fix at point one copies point one
  `TRL_ASSERT_NOW(a_fix_one, m_axis_tvalid && (m_axis_tuser == trl_pkg::ST_ONE), (m_axis_tdata[129:104] == m_axis_tdata[25:0]) && (m_axis_tdata[155:130] == m_axis_tdata[51:26]), "fix differs from point one")

endmodule

bind three_circle_trilateration_unit trl_checker u_trl_checker (.*);
